// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the radix digit converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SITRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sitrd assertion failed");

// next-cycle implication
`define SITRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sitrd assertion failed");

`endif

// ----- rtl/sitrd_pkg.sv -----
// ----------------------------------------------------------------------------
// sitrd_pkg
// Types, constants and the symbol lookup of the radix digit converter.
// ----------------------------------------------------------------------------
package sitrd_pkg;

   localparam int NumW     = 32;
   localparam int NumCells = 32;
   localparam int CountW   = 5;
   localparam int DigitW   = 4;
   localparam int SymW     = 8;
   localparam int MaxBase  = 16;
   localparam int AlphaW   = MaxBase * SymW;
   localparam int CfgW     = 64;
   localparam int IdxW     = 2;

   localparam logic [SymW-1:0] CharMinus = 8'h2D;
   localparam logic [SymW-1:0] CharPlus  = 8'h2B;
   localparam logic [SymW-1:0] CharNul   = 8'h00;

   localparam logic [IdxW-1:0] RegDigitCount  = 2'd0;
   localparam logic [IdxW-1:0] RegAlphabetLow = 2'd1;
   localparam logic [IdxW-1:0] RegAlphabetHigh = 2'd2;

   typedef logic [CountW-1:0] count_type;
   typedef logic [DigitW-1:0] digit_type;
   typedef logic [SymW-1:0]   sym_type;
   typedef logic [AlphaW-1:0] alpha_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic active;
      logic carry;
   } cell_link_type;

   function automatic sym_type sym_at(input alpha_type alpha, input digit_type idx);
      sym_at = alpha[idx*SymW +: SymW];
   endfunction

endpackage

// ----- rtl/sitrd_alpha_check.sv -----
// ----------------------------------------------------------------------------
// sitrd_alpha_check
// Flags whether the configured symbol count and alphabet form a usable base.
// ----------------------------------------------------------------------------
module sitrd_alpha_check (
   input  sitrd_pkg::count_type count,
   input  sitrd_pkg::alpha_type alpha,
   output logic                 ok
);
   import sitrd_pkg::*;

   logic count_ok;
   logic bad;

   assign count_ok = (count >= CountW'(2)) && (count <= CountW'(MaxBase));

   always_comb begin
      bad = 1'b0;
      for (int i = 0; i < MaxBase; i++) begin
         if (CountW'(i) < count) begin
            if (sym_at(alpha, DigitW'(i)) == CharNul || sym_at(alpha, DigitW'(i)) == CharPlus
                || sym_at(alpha, DigitW'(i)) == CharMinus) begin
               bad = 1'b1;
            end
         end
         for (int j = i + 1; j < MaxBase; j++) begin
            if (CountW'(j) < count
                && sym_at(alpha, DigitW'(i)) == sym_at(alpha, DigitW'(j))) begin
               bad = 1'b1;
            end
         end
      end
   end

   assign ok = count_ok && !bad;

endmodule

// ----- rtl/sitrd_cell.sv -----
// ----------------------------------------------------------------------------
// sitrd_cell
// One digit of the doubling chain: digit = 2*digit + carry modulo the radix,
// carry registered before it is handed to the next cell; also a stage of the read-out
// shift line.
// ----------------------------------------------------------------------------
module sitrd_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  sitrd_pkg::cell_ctrl_type ctrl,
   input  sitrd_pkg::count_type     radix,
   input  sitrd_pkg::cell_link_type link_in,
   input  sitrd_pkg::digit_type     digit_lower,
   output sitrd_pkg::cell_link_type link_out,
   output sitrd_pkg::digit_type     digit_out
);
   import sitrd_pkg::*;

   digit_type digit_ff, digit_in;
   logic      active_ff;
   logic      carry_ff, carry_in;
   count_type dbl;
   count_type diff;
   logic      ge;

   assign dbl  = {digit_ff, link_in.carry};
   assign ge   = dbl >= radix;
   assign diff = dbl - radix;

   always_comb begin
      digit_in = digit_ff;
      carry_in = carry_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = digit_lower;
      end else if (link_in.active) begin
         digit_in = ge ? diff[DigitW-1:0] : dbl[DigitW-1:0];
         carry_in = ge;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= link_in.active;
      end
      digit_ff <= digit_in;
      carry_ff <= carry_in;
   end

   assign link_out.active = active_ff;
   assign link_out.carry  = carry_ff;
   assign digit_out       = digit_ff;

endmodule

// ----- rtl/signed_integer_to_radix_digits_core.sv -----
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_core
// Converts a signed 32-bit number to text in a configured alphabet.
// ----------------------------------------------------------------------------
// One number is taken at a time. Magnitude bits enter a row of 32 digit cells
// most significant first; each cell doubles its digit modulo the radix and
// passes its carry on through a register to the next cell. Leading zeros are
// then shifted out of the row at one zero per cycle (up to 31), and each character
// (optional '-' plus the digits) leaves the output register at one per cycle
// while rsp_ready is high. With an unusable alphabet a number is taken and
// dropped with no beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_integer_to_radix_digits_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [sitrd_pkg::NumW-1:0]   req_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sitrd_pkg::SymW-1:0]          rsp_symbol,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [sitrd_pkg::IdxW-1:0]          csr_index,
   input  logic [sitrd_pkg::CfgW-1:0]          csr_wdata
);
   import sitrd_pkg::*;

   localparam int StepW = 6;
   localparam logic [StepW-1:0] ConvLast = StepW'(NumW + NumCells - 2);
   localparam logic [StepW-1:0] FeedEnd  = StepW'(NumW);
   localparam logic [StepW-1:0] AllCells = StepW'(NumCells);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   count_type         count_ff;
   logic [CfgW-1:0]   alpha_lo_ff, alpha_hi_ff;
   alpha_type         alpha;
   logic              alpha_ok;

   logic [1:0]        state_ff, state_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [StepW-1:0]  rem_ff, rem_in;
   logic [NumW-1:0]   mag_ff, mag_in;
   logic              neg_ff, neg_in;

   logic              rsp_valid_ff, rsp_valid_in;
   sym_type           rsp_symbol_ff, rsp_symbol_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              out_free;
   cell_ctrl_type     ctrl;
   cell_link_type     link [0:NumCells];
   digit_type         digit [0:NumCells];
   digit_type         top;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         alpha_lo_ff <= '0;
         alpha_hi_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            RegDigitCount:   count_ff    <= csr_wdata[CountW-1:0];
            RegAlphabetLow:  alpha_lo_ff <= csr_wdata;
            RegAlphabetHigh: alpha_hi_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   assign alpha = {alpha_hi_ff, alpha_lo_ff};

   sitrd_alpha_check u_check (
      .count (count_ff),
      .alpha (alpha),
      .ok    (alpha_ok)
   );

   // digit row
   assign link[0].active = (state_ff == ST_CONV) && (step_ff < FeedEnd);
   assign link[0].carry  = mag_ff[NumW-1];
   assign digit[0]       = '0;

   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      sitrd_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .radix       (count_ff),
         .link_in     (link[k]),
         .digit_lower (digit[k]),
         .link_out    (link[k+1]),
         .digit_out   (digit[k+1])
      );
   end

   assign top       = digit[NumCells];
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ctrl.clear    = 1'b0;
      ctrl.shift    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && alpha_ok) begin
               neg_in     = req_number[NumW-1];
               mag_in     = req_number[NumW-1] ? (NumW'(0) - unsigned'(req_number))
                                               : unsigned'(req_number);
               step_in    = '0;
               ctrl.clear = 1'b1;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            mag_in  = {mag_ff[NumW-2:0], 1'b0};
            step_in = step_ff + StepW'(1);
            if (step_ff == ConvLast) begin
               rem_in   = AllCells;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top == '0 && rem_ff != StepW'(1)) begin
               ctrl.shift = 1'b1;
               rem_in     = rem_ff - StepW'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_symbol_in = CharMinus;
                  rsp_last_in   = 1'b0;
                  neg_in        = 1'b0;
               end else begin
                  rsp_symbol_in = sym_at(alpha, top);
                  rsp_last_in   = (rem_ff == StepW'(1));
                  ctrl.shift    = 1'b1;
                  rem_in        = rem_ff - StepW'(1);
                  if (rem_ff == StepW'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rem_ff       <= '0;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rem_ff       <= rem_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   `SITRD_ASSERT_NEXT(a_conv_to_skip, clock, reset,
      state_ff == ST_CONV && step_ff == ConvLast, state_ff == ST_SKIP && rem_ff == AllCells)
   `SITRD_ASSERT_NEXT(a_skip_stops, clock, reset,
      state_ff == ST_SKIP && (top != '0 || rem_ff == StepW'(1)), state_ff == ST_EMIT)
   `SITRD_ASSERT_IMPL(a_emit_has_digit, clock, reset,
      state_ff == ST_EMIT || state_ff == ST_SKIP, rem_ff != '0)
   `SITRD_ASSERT_NEXT(a_last_ends_item, clock, reset,
      state_ff == ST_EMIT && out_free && !neg_ff && rem_ff == StepW'(1),
      state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff)

endmodule
